// ===== sv/mau_pkg.sv =====
// Package for the modular arithmetic unit: widths, action codes and sequencer states.
package mau_pkg;

  localparam int unsigned ModWidth = 31;
  localparam int unsigned OpWidth  = 64;
  localparam int unsigned ExpWidth = 31;
  localparam int unsigned CntWidth = 6;
  localparam logic [ModWidth-1:0] ModReset = 31'd1000000007;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_POW = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_FIX,
    ST_DISP,
    ST_MUL,
    ST_MULRES,
    ST_EU_CHK,
    ST_DIV,
    ST_EU_UPD,
    ST_PW_CHK,
    ST_PW_ACC,
    ST_PW_SQ,
    ST_FIN
  } state_e;

endpackage

// ===== sv/modular_arithmetic_unit.sv =====
// Modular arithmetic unit: bit-serial reduction, multiplication, division and sequencing.
// Every action starts with two bit-serial 64-bit operand reductions, which is all that add
// and subtract need besides the final add or subtract; multiply adds one modular multiply,
// divide runs one division and one multiply per Euclid iteration, power up to 62 multiplies.
// Throughput: one request at a time; the next is accepted while a result waits.
// Reset is asynchronous and active low; it sets the modulus to 1000000007.
module modular_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // left_value[63:0], right_value[127:64], exponent[158:128]
  input  logic [2:0]   s_axis_tuser,  // action[2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // result_value[30:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import mau_pkg::*;

  state_e state_q, state_d, mret_q;
  logic [ModWidth-1:0] mod_q, m_eff, one_m;
  logic [OpWidth-1:0]  x_q, rmag_q;
  logic                lneg_q, rneg_q, sel_q;
  logic [2:0]          act_q;
  logic [ExpWidth-1:0] k_q;
  logic [CntWidth-1:0] cnt_q;
  logic [ModWidth-1:0] red_q, l_q, r_q;
  logic [ModWidth-1:0] ma_q, mb_q, macc_q;
  logic [ModWidth-1:0] ea_q, eb_q, eu_q, ev_q, dn_q, dq_q, drem_q;
  logic [ModWidth-1:0] pacc_q, base_q;
  logic [ModWidth-1:0] out_q;
  logic                out_valid_q;
  logic                accept, fin_load;

  logic [31:0]         red2;
  logic [ModWidth-1:0] red_nx;
  logic [32:0]         ms, ms1, ms2;
  logic [ModWidth-1:0] macc_nx;
  logic [31:0]         dr2;
  logic                dge;
  logic [ModWidth-1:0] fix_val, add_val, sub_val, nu_val, disp_res;
  logic [32:0]         add_s;
  logic [OpWidth-1:0]  lraw, rraw;

  assign m_eff = (mod_q == '0) ? ModWidth'(1) : mod_q;
  assign one_m = (m_eff == ModWidth'(1)) ? '0 : ModWidth'(1);
  assign lraw  = s_axis_tdata[63:0];
  assign rraw  = s_axis_tdata[127:64];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {1'b0, mod_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mod_q <= pwdata[ModWidth-1:0];
    end
  end

  // Bit-serial datapath steps and combinational sign-fix, add and subtract values
  always_comb begin
    red2   = {red_q, x_q[OpWidth-1]};
    red_nx = (red2 >= {1'b0, m_eff}) ? ModWidth'(red2 - {1'b0, m_eff}) : red2[ModWidth-1:0];
    ms     = {1'b0, macc_q, 1'b0} + (mb_q[ModWidth-1] ? {2'b00, ma_q} : 33'd0);
    ms1    = ms - {2'b00, m_eff};
    ms2    = ms - {1'b0, m_eff, 1'b0};
    if (!ms2[32]) begin
      macc_nx = ms2[ModWidth-1:0];
    end else if (!ms1[32]) begin
      macc_nx = ms1[ModWidth-1:0];
    end else begin
      macc_nx = ms[ModWidth-1:0];
    end
    dr2     = {drem_q, dn_q[ModWidth-1]};
    dge     = (dr2 >= {1'b0, eb_q});
    fix_val = ((sel_q ? rneg_q : lneg_q) && red_q != '0) ? m_eff - red_q : red_q;
    add_s   = {2'b00, l_q} + {2'b00, r_q};
    add_val = (add_s >= {2'b00, m_eff}) ? ModWidth'(add_s - {2'b00, m_eff}) : add_s[ModWidth-1:0];
    sub_val = (l_q < r_q) ? ModWidth'({1'b0, l_q} + {1'b0, m_eff} - {1'b0, r_q}) : l_q - r_q;
    nu_val  = (eu_q < macc_q) ? ModWidth'({1'b0, eu_q} + {1'b0, m_eff} - {1'b0, macc_q})
                              : eu_q - macc_q;
    case (act_q)
      ACT_ADD: disp_res = add_val;
      ACT_SUB: disp_res = sub_val;
      default: disp_res = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_RED;
      ST_RED:    if (cnt_q == '0) state_d = ST_FIX;
      ST_FIX:    state_d = sel_q ? ST_DISP : ST_RED;
      ST_DISP: begin
        case (act_q)
          ACT_MUL: state_d = ST_MUL;
          ACT_DIV: state_d = ST_EU_CHK;
          ACT_POW: state_d = ST_PW_CHK;
          default: state_d = ST_FIN;
        endcase
      end
      ST_MUL:    if (cnt_q == '0) state_d = mret_q;
      ST_MULRES: state_d = ST_FIN;
      ST_EU_CHK: state_d = (eb_q == '0) ? ST_MUL : ST_DIV;
      ST_DIV:    if (cnt_q == '0) state_d = ST_MUL;
      ST_EU_UPD: state_d = ST_EU_CHK;
      ST_PW_CHK: state_d = (k_q == '0) ? ST_FIN : ST_MUL;
      ST_PW_ACC: state_d = ST_MUL;
      ST_PW_SQ:  state_d = ST_PW_CHK;
      ST_FIN:    if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    accept        = s_axis_tready && s_axis_tvalid;
    fin_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      out_q <= macc_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_q  <= s_axis_tuser;
          k_q    <= s_axis_tdata[158:128];
          lneg_q <= lraw[OpWidth-1];
          rneg_q <= rraw[OpWidth-1];
          x_q    <= lraw[OpWidth-1] ? (~lraw) + OpWidth'(1) : lraw;
          rmag_q <= rraw[OpWidth-1] ? (~rraw) + OpWidth'(1) : rraw;
          sel_q  <= 1'b0;
          red_q  <= '0;
          cnt_q  <= CntWidth'(OpWidth - 1);
        end
      end
      ST_RED: begin
        red_q <= red_nx;
        x_q   <= {x_q[OpWidth-2:0], 1'b0};
        cnt_q <= cnt_q - CntWidth'(1);
      end
      ST_FIX: begin
        if (sel_q) begin
          r_q <= fix_val;
        end else begin
          l_q   <= fix_val;
          x_q   <= rmag_q;
          sel_q <= 1'b1;
          red_q <= '0;
          cnt_q <= CntWidth'(OpWidth - 1);
        end
      end
      ST_DISP: begin
        macc_q <= disp_res;
        cnt_q  <= CntWidth'(ModWidth - 1);
        case (act_q)
          ACT_MUL: begin
            ma_q   <= l_q;
            mb_q   <= r_q;
            mret_q <= ST_MULRES;
          end
          ACT_DIV: begin
            ea_q <= r_q;
            eb_q <= m_eff;
            eu_q <= one_m;
            ev_q <= '0;
          end
          ACT_POW: begin
            pacc_q <= one_m;
            base_q <= l_q;
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        macc_q <= macc_nx;
        mb_q   <= {mb_q[ModWidth-2:0], 1'b0};
        cnt_q  <= cnt_q - CntWidth'(1);
      end
      ST_EU_CHK: begin
        cnt_q <= CntWidth'(ModWidth - 1);
        if (eb_q == '0) begin
          ma_q   <= l_q;
          mb_q   <= eu_q;
          macc_q <= '0;
          mret_q <= ST_MULRES;
        end else begin
          dn_q   <= ea_q;
          dq_q   <= '0;
          drem_q <= '0;
        end
      end
      ST_DIV: begin
        drem_q <= dge ? ModWidth'(dr2 - {1'b0, eb_q}) : dr2[ModWidth-1:0];
        dq_q   <= {dq_q[ModWidth-2:0], dge};
        dn_q   <= {dn_q[ModWidth-2:0], 1'b0};
        if (cnt_q == '0) begin
          ma_q   <= ev_q;
          mb_q   <= {dq_q[ModWidth-2:0], dge};
          macc_q <= '0;
          mret_q <= ST_EU_UPD;
          cnt_q  <= CntWidth'(ModWidth - 1);
        end else begin
          cnt_q <= cnt_q - CntWidth'(1);
        end
      end
      ST_EU_UPD: begin
        ea_q <= eb_q;
        eb_q <= drem_q;
        eu_q <= ev_q;
        ev_q <= nu_val;
      end
      ST_PW_CHK: begin
        cnt_q  <= CntWidth'(ModWidth - 1);
        macc_q <= (k_q == '0) ? pacc_q : '0;
        if (k_q[0]) begin
          ma_q   <= base_q;
          mb_q   <= pacc_q;
          mret_q <= ST_PW_ACC;
        end else begin
          ma_q   <= base_q;
          mb_q   <= base_q;
          mret_q <= ST_PW_SQ;
        end
      end
      ST_PW_ACC: begin
        pacc_q <= macc_q;
        ma_q   <= base_q;
        mb_q   <= base_q;
        macc_q <= '0;
        mret_q <= ST_PW_SQ;
        cnt_q  <= CntWidth'(ModWidth - 1);
      end
      ST_PW_SQ: begin
        base_q <= macc_q;
        k_q    <= {1'b0, k_q[ExpWidth-1:1]};
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_result_below_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (macc_q < m_eff))
    else $error("result not reduced below the modulus");

  a_remainder_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EU_UPD) |-> (drem_q < eb_q))
    else $error("division remainder not below divisor");

  a_fin_holds_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !m_axis_tready) |=> (state_q == ST_FIN))
    else $error("result overwritten while the previous one waits");
`endif

endmodule
